// ===== rtl/crc8d_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8d_pkg
// Shared constants, phase and status codes and the CRC-8 step for the deframer.
// ----------------------------------------------------------------------------
package crc8d_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0] LEN_MIN = 8'd2;
  localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD + 2);

  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam logic [7:0] MAGIC_FIRST_RST  = 8'd35;
  localparam logic [7:0] MAGIC_SECOND_RST = 8'd64;
  localparam logic [7:0] MAGIC_THIRD_RST  = 8'd33;

  localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
  localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAGIC_THIRD  = 2'd2;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_THIRD   = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CRC     = 3'd5;

  localparam logic [1:0] ST_DATA   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_CRCERR = 2'd2;
  localparam logic [1:0] ST_LENERR = 2'd3;

  typedef logic [7:0] byte_t;

  function automatic byte_t crc8_update(input byte_t crc, input byte_t b);
    byte_t c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/crc8_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// crc8_packet_deframer
// Marker/length/CRC-8 packet deframer with payload buffered in a RAM.
// A status result is registered, in the cycle after the byte that causes it;
// the first payload byte follows the CRC byte via RAM read and output regs.
// Framing takes 1 byte per cycle unless the output stalls; draining gives 1
// payload byte per unstalled cycle via the RAM read register, input held off.
// Reset: synchronous active-low, clears control state and restores markers.
// ----------------------------------------------------------------------------
module crc8_packet_deframer
  import crc8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_last
);

  logic [7:0]       magic1_r, magic2_r, magic3_r;
  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [CNT_W-1:0] need_r, need_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drain_r, drain_nxt;
  logic             data_ok_r, data_ok_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  logic              in_fire;
  logic              out_free;
  logic [7:0]        crc_step;
  logic [7:0]        crc_first;
  logic              ram_we;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [7:0]        ram_rd_data;
  logic [CNT_W-1:0]  idx_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = drain_r || (out_valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign crc_step  = crc8_update(crc_r, in_rx_byte);
  assign crc_first = crc8_update(8'd0, in_rx_byte);
  assign idx_inc   = rd_idx_r + CNT_W'(1);

  crc8d_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    phase_nxt      = phase_r;
    crc_nxt        = crc_r;
    need_nxt       = need_r;
    cnt_nxt        = cnt_r;
    drain_nxt      = drain_r;
    data_ok_nxt    = data_ok_r;
    rd_idx_nxt     = rd_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = rd_idx_r[ADDR_W-1:0];

    if (in_fire) begin
      unique case (phase_r)
        PH_SECOND, PH_THIRD: begin
          if ((phase_r == PH_SECOND && in_rx_byte == magic2_r) ||
              (phase_r == PH_THIRD && in_rx_byte == magic3_r)) begin
            crc_nxt   = crc_step;
            phase_nxt = (phase_r == PH_SECOND) ? PH_THIRD : PH_LENGTH;
          end else if (in_rx_byte == magic1_r) begin
            crc_nxt   = crc_first;
            phase_nxt = PH_SECOND;
          end else begin
            crc_nxt   = 8'd0;
            phase_nxt = PH_HUNT;
          end
        end
        PH_LENGTH: begin
          cnt_nxt = '0;
          if (in_rx_byte < LEN_MIN || in_rx_byte > LEN_MAX) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = 8'd0;
            out_status_nxt = ST_LENERR;
            out_last_nxt   = 1'b1;
            crc_nxt        = 8'd0;
            phase_nxt      = PH_HUNT;
          end else begin
            crc_nxt   = crc_step;
            need_nxt  = CNT_W'(in_rx_byte - LEN_MIN);
            phase_nxt = (in_rx_byte == LEN_MIN) ? PH_CRC : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          ram_we  = 1'b1;
          crc_nxt = crc_step;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r + CNT_W'(1) >= need_r) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          crc_nxt   = 8'd0;
          phase_nxt = PH_HUNT;
          if (in_rx_byte != crc_r) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = 8'd0;
            out_status_nxt = ST_CRCERR;
            out_last_nxt   = 1'b1;
          end else if (need_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = 8'd0;
            out_status_nxt = ST_EMPTY;
            out_last_nxt   = 1'b1;
          end else begin
            drain_nxt   = 1'b1;
            data_ok_nxt = 1'b1;
            rd_idx_nxt  = '0;
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
          end
        end
        default: begin
          if (in_rx_byte == magic1_r) begin
            crc_nxt   = crc_first;
            phase_nxt = PH_SECOND;
          end else begin
            crc_nxt   = 8'd0;
            phase_nxt = PH_HUNT;
          end
        end
      endcase
    end

    // payload drain from the store
    if (drain_r && data_ok_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = ram_rd_data;
      out_status_nxt = ST_DATA;
      out_last_nxt   = (idx_inc == need_r);
      if (idx_inc == need_r) begin
        drain_nxt   = 1'b0;
        data_ok_nxt = 1'b0;
      end else begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx_inc[ADDR_W-1:0];
        rd_idx_nxt  = idx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic1_r    <= MAGIC_FIRST_RST;
      magic2_r    <= MAGIC_SECOND_RST;
      magic3_r    <= MAGIC_THIRD_RST;
      phase_r     <= PH_HUNT;
      crc_r       <= 8'd0;
      need_r      <= '0;
      cnt_r       <= '0;
      drain_r     <= 1'b0;
      data_ok_r   <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAGIC_FIRST:  magic1_r <= cfg_wdata;
          REG_MAGIC_SECOND: magic2_r <= cfg_wdata;
          REG_MAGIC_THIRD:  magic3_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      phase_r     <= phase_nxt;
      crc_r       <= crc_nxt;
      need_r      <= need_nxt;
      cnt_r       <= cnt_nxt;
      drain_r     <= drain_nxt;
      data_ok_r   <= data_ok_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  a_no_accept_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> !in_fire)
    else $error("request accepted while draining payload");

  a_drain_index: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> (rd_idx_r < need_r))
    else $error("drain index beyond packet length");

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (cnt_r < need_r))
    else $error("payload count beyond packet length");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_DATA) |-> (out_last_r && out_byte_r == 8'd0))
    else $error("status result without last mark or with nonzero byte");

endmodule

// ===== rtl/crc8d_ram.sv =====
// ----------------------------------------------------------------------------
// crc8d_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module crc8d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sim/crc8_packet_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_packet_deframer_tb
// Self-checking bench for the marker/length/CRC-8 deframer. Byte streams with
// good, corrupted, empty and bad-length packets plus line noise are pushed in
// under random sender gaps and receiver stalls; a local deframer predicts
// every result, which is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module crc8_packet_deframer_tb
  import crc8d_pkg::*;
();

  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         HOLD_CYCLES   = 200;
  localparam int         ITEM_BUDGET   = 120;
  localparam int         MAX_REPORTS   = 10;
  localparam logic [1:0] REG_SPARE     = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct packed {
    byte_t      data;
    logic [1:0] status;
    logic       last;
  } packet_result_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic [1:0] cfg_index  = 2'd0;
  logic [7:0] cfg_wdata  = 8'h00;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_last;

  crc8_packet_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

  always #4 clk = ~clk;

  // predicted deframer state and marker registers
  byte_t      marker_first  = MAGIC_FIRST_RST;
  byte_t      marker_second = MAGIC_SECOND_RST;
  byte_t      marker_third  = MAGIC_THIRD_RST;
  logic [2:0] frame_phase   = PH_HUNT;
  byte_t      frame_len     = 8'h00;
  int         stored_count  = 0;
  byte_t      frame_crc     = 8'h00;
  byte_t      payload_mem [MAX_PAYLOAD];

  packet_result_t results_due [$];
  packet_result_t want;
  byte_t          frame_buf [$];
  byte_t          payload_buf [$];

  stall_mode_t stall_mode = STALL_NONE;
  logic        hold_req   = 1'b0;
  int          hold_left  = 0;
  int          stall_tick = 0;
  logic        gaps_on    = 1'b1;
  int          burst_left = 4;

  int cycle_count   = 0;
  int errors        = 0;
  int items_sent    = 0;
  int results_total = 0;
  int results_seen  = 0;
  int reg_writes    = 0;
  int status_count [4] = '{0, 0, 0, 0};

  function automatic byte_t crc8_next(input byte_t acc, input byte_t b);
    byte_t r;
    r = acc ^ b;
    repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  task automatic push_result(input byte_t d, input logic [1:0] st, input logic lst);
    packet_result_t r;
    r.data   = d;
    r.status = st;
    r.last   = lst;
    results_due = {results_due, r};
    results_total++;
  endtask

  task automatic add_frame_byte(input byte_t b);
    frame_buf = {frame_buf, b};
  endtask

  task automatic add_payload_byte(input byte_t b);
    payload_buf = {payload_buf, b};
  endtask

  task automatic end_frame();
    frame_phase = PH_HUNT;
    frame_crc   = 8'h00;
  endtask

  task automatic restart_hunt(input byte_t b);
    if (b == marker_first) begin
      frame_crc   = crc8_next(8'h00, b);
      frame_phase = PH_SECOND;
    end else begin
      end_frame();
    end
  endtask

  task automatic deframe_step(input byte_t b);
    int need;
    need = int'(frame_len) - 2;
    case (frame_phase)
      PH_HUNT: restart_hunt(b);
      PH_SECOND: begin
        if (b == marker_second) begin
          frame_crc   = crc8_next(frame_crc, b);
          frame_phase = PH_THIRD;
        end else begin
          restart_hunt(b);
        end
      end
      PH_THIRD: begin
        if (b == marker_third) begin
          frame_crc   = crc8_next(frame_crc, b);
          frame_phase = PH_LENGTH;
        end else begin
          restart_hunt(b);
        end
      end
      PH_LENGTH: begin
        frame_len    = b;
        stored_count = 0;
        if (b < LEN_MIN || b > LEN_MAX) begin
          push_result(8'h00, ST_LENERR, 1'b1);
          end_frame();
        end else begin
          frame_crc   = crc8_next(frame_crc, b);
          frame_phase = (b == LEN_MIN) ? PH_CRC : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (stored_count < MAX_PAYLOAD) payload_mem[stored_count] = b;
        frame_crc    = crc8_next(frame_crc, b);
        stored_count = (stored_count + 1) & 8'h7F;
        if (stored_count >= need) frame_phase = PH_CRC;
      end
      PH_CRC: begin
        if (b != frame_crc) begin
          push_result(8'h00, ST_CRCERR, 1'b1);
        end else if (need == 0 || need > MAX_PAYLOAD) begin
          push_result(8'h00, ST_EMPTY, 1'b1);
        end else begin
          for (int k = 0; k < need; k++) push_result(payload_mem[k], ST_DATA, k + 1 == need);
        end
        end_frame();
      end
      default: begin
        end_frame();
        restart_hunt(b);
      end
    endcase
  endtask

  task automatic send_byte(input byte_t b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_step(b);
    items_sent++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end
    end
  endtask

  task automatic send_frame(input int first);
    for (int i = first; i < frame_buf.size(); i++) send_byte(frame_buf[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input byte_t v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAGIC_FIRST:  marker_first  = v;
      REG_MAGIC_SECOND: marker_second = v;
      REG_MAGIC_THIRD:  marker_third  = v;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic fill_payload(input int n);
    payload_buf.delete();
    repeat (n) add_payload_byte(byte_t'($urandom_range(0, 255)));
  endtask

  // marker, length, payload_buf and crc into frame_buf
  task automatic queue_frame(input byte_t m0, input byte_t m1, input byte_t m2,
                             input logic bad_crc);
    byte_t c;
    frame_buf.delete();
    add_frame_byte(m0);
    add_frame_byte(m1);
    add_frame_byte(m2);
    add_frame_byte(byte_t'(payload_buf.size() + 2));
    foreach (payload_buf[i]) add_frame_byte(payload_buf[i]);
    c = 8'h00;
    foreach (frame_buf[i]) c = crc8_next(c, frame_buf[i]);
    if (bad_crc) c ^= byte_t'($urandom_range(1, 255));
    add_frame_byte(c);
  endtask

  task automatic queue_bad_length(input byte_t len);
    frame_buf.delete();
    add_frame_byte(marker_first);
    add_frame_byte(marker_second);
    add_frame_byte(marker_third);
    add_frame_byte(len);
  endtask

  task automatic send_random_packet();
    int pick;
    pick = $urandom_range(0, 99);
    frame_buf.delete();
    if (pick < 72) begin
      fill_payload(($urandom_range(0, 11) == 0) ? MAX_PAYLOAD : $urandom_range(0, 8));
      queue_frame(marker_first, marker_second, marker_third, pick >= 60);
    end else if (pick < 80) begin
      queue_bad_length($urandom_range(0, 1) ? byte_t'($urandom_range(0, 1))
                                            : byte_t'($urandom_range(int'(LEN_MAX) + 1, 255)));
    end else if (pick < 90) begin
      // marker cut short by a wrong byte
      add_frame_byte(marker_first);
      if ($urandom_range(0, 1)) begin
        add_frame_byte(marker_second);
        add_frame_byte(marker_third ^ byte_t'($urandom_range(1, 255)));
      end else begin
        add_frame_byte(marker_second ^ byte_t'($urandom_range(1, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 5)) add_frame_byte(byte_t'($urandom_range(0, 255)));
    end
    send_frame(0);
  endtask

  task automatic test_framing_basics();
    stall_mode = STALL_LIGHT;
    gaps_on    = 1'b1;
    // marker restarts in both middle phases, then a too-short length
    frame_buf.delete();
    add_frame_byte(marker_first);
    add_frame_byte(marker_first);
    add_frame_byte(marker_second);
    add_frame_byte(marker_first);
    add_frame_byte(marker_second);
    add_frame_byte(marker_third);
    add_frame_byte(8'h01);
    send_frame(0);
    payload_buf.delete();
    queue_frame(marker_first, marker_second, marker_third, 1'b0);
    send_frame(0);
    payload_buf.delete();
    add_payload_byte(8'h00);
    queue_frame(marker_first, marker_second, marker_third, 1'b1);
    send_frame(0);
    wait_drained();
  endtask

  task automatic test_largest_packet();
    stall_mode = STALL_PERIODIC;
    fill_payload(MAX_PAYLOAD);
    queue_frame(marker_first, marker_second, marker_third, 1'b0);
    send_frame(0);
    queue_bad_length(LEN_MAX + 8'd1);
    send_frame(0);
    wait_drained();
  endtask

  task automatic test_marker_registers();
    stall_mode = STALL_LIGHT;
    write_reg(REG_MAGIC_FIRST, 8'h00);
    write_reg(REG_MAGIC_SECOND, 8'hFF);
    write_reg(REG_MAGIC_THIRD, 8'h80);
    send_random_packet();
    write_reg(REG_SPARE, 8'hA5);
    write_reg(REG_MAGIC_FIRST, 8'hFF);
    write_reg(REG_MAGIC_SECOND, 8'h00);
    // third marker byte changes while the packet is under way
    fill_payload(3);
    queue_frame(8'hFF, 8'h00, 8'h7F, 1'b0);
    send_byte(frame_buf[0]);
    send_byte(frame_buf[1]);
    write_reg(REG_MAGIC_THIRD, 8'h7F);
    send_frame(2);
    send_random_packet();
    write_reg(REG_MAGIC_FIRST, MAGIC_FIRST_RST);
    write_reg(REG_MAGIC_SECOND, MAGIC_SECOND_RST);
    write_reg(REG_MAGIC_THIRD, MAGIC_THIRD_RST);
  endtask

  task automatic test_input_backpressure();
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    hold_req   = 1'b1;
    repeat (3) begin
      fill_payload(2);
      queue_frame(marker_first, marker_second, marker_third, 1'b0);
      send_frame(0);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    gaps_on = 1'b1;
    while (items_sent < ITEM_BUDGET) begin
      if ($urandom_range(0, 5) == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        gaps_on    = 1'($urandom_range(0, 1));
      end
      send_random_packet();
    end
    wait_drained();
  endtask

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
        STALL_PERIODIC: out_stall <= (stall_tick % 7 < 3);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      status_count[out_status]++;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected result: byte %02h status %0d last %0b",
                   out_byte, out_status, out_last);
        end
      end else begin
        want = results_due.pop_front();
        if (out_byte !== want.data || out_status !== want.status || out_last !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("mismatch at result %0d: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                     results_seen, want.data, want.status, want.last,
                     out_byte, out_status, out_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("crc8_packet_deframer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_framing_basics();
    test_largest_packet();
    test_marker_registers();
    test_input_backpressure();
    test_random_traffic();
    wait_drained();
    $display("covered %0d input bytes, %0d register writes, %0d of %0d results, %0d errors",
             items_sent, reg_writes, results_seen, results_total, errors);
    $display("results by kind: data %0d, empty %0d, crc error %0d, length error %0d",
             status_count[ST_DATA], status_count[ST_EMPTY],
             status_count[ST_CRCERR], status_count[ST_LENERR]);
    if (errors == 0 && results_due.size() == 0) begin
      $display("crc8_packet_deframer_tb: done, clean");
    end else begin
      $display("crc8_packet_deframer_tb: done, errors");
    end
    $finish;
  end

endmodule
